FILE: hw/rtl/ats_pkg.sv
package ats_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned RateW    = 37;
  localparam int unsigned BurstW   = 32;
  localparam int unsigned SidW     = 8;
  localparam int unsigned LenW     = 14;
  localparam int unsigned BitsW    = LenW + 3;
  localparam int unsigned NumW     = BurstW;
  localparam int unsigned NsW      = 30;
  localparam int unsigned ProdW    = NumW + NsW;
  localparam int unsigned CfgW     = TimeW;
  localparam int unsigned InDataW  = ((SidW + LenW + TimeW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((1 + TimeW + 7) / 8) * 8;

  localparam int unsigned DefStreams = 256;

  localparam logic [NsW-1:0]    NsPerS     = NsW'(1000000000);
  localparam logic [TimeW-1:0]  TimeMax    = {TimeW{1'b1}};
  localparam logic [RateW-1:0]  RateReset  = RateW'(10000000);
  localparam logic [BurstW-1:0] BurstReset = BurstW'(16384);
  localparam logic [TimeW-1:0]  ResReset   = TimeW'(1000000000);

  typedef enum logic [1:0] {
    CfgRate      = 2'd0,
    CfgBurst     = 2'd1,
    CfgResidence = 2'd2
  } cfg_idx_e;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

FILE: hw/rtl/ats_div.sv
module ats_div import ats_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NumW-1:0]   numer_i,
  input  logic [RateW-1:0]  rate_i,
  output logic              done_o,
  output logic [TimeW-1:0]  quot_o
);

  typedef enum logic [1:0] {
    DIdle,
    DCheck,
    DRun
  } div_state_e;

  localparam int unsigned CntW = $clog2(TimeW);

  div_state_e          state_q, state_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [RateW-1:0]    rem_q, rem_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [RateW:0]      trial;
  logic                ge;

  // one restoring step: bring down the next dividend bit
  assign trial = {rem_q, prod_q[TimeW-1]};
  assign ge    = trial >= {1'b0, rate_i};

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      DIdle: begin
        if (start_i) begin
          prod_d  = ProdW'(numer_i) * ProdW'(NsPerS);
          state_d = DCheck;
        end
      end
      DCheck: begin
        // quotient would not fit the time width: saturate
        if (RateW'(prod_q[ProdW-1:TimeW]) >= rate_i) begin
          prod_d[TimeW-1:0] = TimeMax;
          done_d            = 1'b1;
          state_d           = DIdle;
        end else begin
          rem_d   = RateW'(prod_q[ProdW-1:TimeW]);
          cnt_d   = '0;
          state_d = DRun;
        end
      end
      DRun: begin
        rem_d             = ge ? RateW'(trial - {1'b0, rate_i}) : trial[RateW-1:0];
        prod_d[TimeW-1:0] = {prod_q[TimeW-2:0], ge};
        cnt_d             = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TimeW - 1)) begin
          done_d  = 1'b1;
          state_d = DIdle;
        end
      end
      default: state_d = DIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIdle;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = prod_q[TimeW-1:0];

endmodule

FILE: hw/rtl/ats_eligibility_time_shaper.sv
// Token-bucket eligibility time per frame. Each input beat carries a stream id, a frame
// length in bytes and the current time in ns; each output beat carries the accept flag
// and the eligibility time. One frame is processed at a time. The length-recovery and the
// empty-to-full durations each take one pass through the shared bit-serial divider: a
// multiply, a range check and, unless the quotient saturates, 48 restoring steps. A zero
// committed rate drops the frame without a divider pass. A short tail of saturating adds
// shares a single adder, with an extra step when the bucket-empty time must also be
// pushed past the full point. A result beat that waits at the output does not block the
// next frame from being taken, but that frame holds in its last step until the beat is
// gone. Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while
// idle; the user must keep to this, as the block itself does not enforce it.
module ats_eligibility_time_shaper import ats_pkg::*; #(
  parameter int unsigned STREAMS = DefStreams
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // stream_id [7:0], frame_bytes [21:8], now_ns [69:22], zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // accepted [0], eligibility_ns [48:1], zero fill
  output logic [OutDataW-1:0] m_axis_tdata
);

  // ids are 8 bits wide, so no more than 256 entries are ever reachable
  localparam int unsigned Depth = (STREAMS < (1 << SidW)) ? STREAMS : (1 << SidW);
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [3:0] {
    SIdle,
    SLookup,
    SRec,
    SFill,
    SSched,
    SFull,
    SLimit,
    SMax,
    SDecide,
    SUpdate,
    SDone
  } state_e;

  // wrap the id onto the table: one compare and subtract per id bit
  function automatic logic [IdxW-1:0] wrap_sid(input logic [SidW-1:0] sid);
    logic [SidW:0] r;
    r = '0;
    for (int i = SidW - 1; i >= 0; i--) begin
      r = {r[SidW-1:0], sid[i]};
      if (r >= (SidW + 1)'(Depth)) r = r - (SidW + 1)'(Depth);
    end
    return IdxW'(r);
  endfunction

  state_e             state_q;
  logic [RateW-1:0]   rate_q;
  logic [BurstW-1:0]  burst_q;
  logic [TimeW-1:0]   res_q;
  logic [Depth-1:0]   valid_q;
  logic [TimeW-1:0]   grp_q;
  logic               m_valid_q;
  logic               acc_out_q;
  logic [TimeW-1:0]   elig_out_q;

  logic [IdxW-1:0]    sid_q;
  logic [BitsW-1:0]   bits_q;
  logic [TimeW-1:0]   now_q, bet_q, rec_q, fill_q, sched_q, full_q, lim_q, elig_q, diff_q;
  logic               acc_q;

  logic [TimeW-1:0]   mem [Depth];
  logic [TimeW-1:0]   rd_q;
  logic               mem_we;
  logic [TimeW-1:0]   mem_wdata;
  logic [IdxW-1:0]    in_sid;

  logic               in_fire;
  logic               div_start, div_done;
  logic [NumW-1:0]    div_numer;
  logic [TimeW-1:0]   div_quot;
  logic [TimeW-1:0]   add_a, add_b, add_s;
  logic [TimeW-1:0]   elig_max;

  assign s_axis_tready = (state_q == SIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_sid        = wrap_sid(s_axis_tdata[SidW-1:0]);

  assign div_start = ((state_q == SLookup) && (rate_q != '0)) ||
                     ((state_q == SRec) && div_done);
  assign div_numer = (state_q == SLookup) ? NumW'(bits_q) : burst_q;

  ats_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .rate_i  (rate_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // shared saturating adder
  always_comb begin
    case (state_q)
      SFull:   begin add_a = bet_q;   add_b = fill_q; end
      SLimit:  begin add_a = now_q;   add_b = res_q;  end
      SUpdate: begin add_a = sched_q; add_b = diff_q; end
      default: begin add_a = bet_q;   add_b = rec_q;  end
    endcase
  end
  assign add_s = sat_add(add_a, add_b);

  always_comb begin
    elig_max = now_q;
    if (grp_q > elig_max) elig_max = grp_q;
    if (sched_q > elig_max) elig_max = sched_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sched_q;
    case (state_q)
      SLookup: begin
        mem_we    = !valid_q[sid_q];
        mem_wdata = now_q;
      end
      SDecide: mem_we = (elig_q <= lim_q) && (elig_q < full_q);
      SUpdate: begin
        mem_we    = 1'b1;
        mem_wdata = add_s;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[sid_q] <= mem_wdata;
    rd_q <= mem[in_sid];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RateReset;
      burst_q <= BurstReset;
      res_q   <= ResReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRate:      rate_q  <= cfg_wdata_i[RateW-1:0];
        CfgBurst:     burst_q <= cfg_wdata_i[BurstW-1:0];
        CfgResidence: res_q   <= cfg_wdata_i[TimeW-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      valid_q    <= '0;
      grp_q      <= '0;
      m_valid_q  <= 1'b0;
      acc_out_q  <= 1'b0;
      elig_out_q <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != SDone)) m_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (in_fire) state_q <= SLookup;
        end
        SLookup: begin
          valid_q[sid_q] <= 1'b1;
          if (rate_q == '0) begin
            acc_q   <= 1'b0;
            state_q <= SDone;
          end else begin
            state_q <= SRec;
          end
        end
        SRec: begin
          if (div_done) state_q <= SFill;
        end
        SFill: begin
          if (div_done) state_q <= SSched;
        end
        SSched:  state_q <= SFull;
        SFull:   state_q <= SLimit;
        SLimit:  state_q <= SMax;
        SMax:    state_q <= SDecide;
        SDecide: begin
          if (elig_q <= lim_q) begin
            acc_q   <= 1'b1;
            grp_q   <= elig_q;
            state_q <= (elig_q < full_q) ? SDone : SUpdate;
          end else begin
            acc_q   <= 1'b0;
            state_q <= SDone;
          end
        end
        SUpdate: state_q <= SDone;
        SDone: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            acc_out_q  <= acc_q;
            elig_out_q <= elig_q;
            state_q    <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sid_q  <= in_sid;
      bits_q <= {s_axis_tdata[SidW +: LenW], 3'b000};
      now_q  <= s_axis_tdata[SidW + LenW +: TimeW];
    end
    if (state_q == SLookup) bet_q <= valid_q[sid_q] ? rd_q : now_q;
    if (state_q == SLookup && rate_q == '0) elig_q <= now_q;
    if (state_q == SRec && div_done) rec_q <= div_quot;
    if (state_q == SFill && div_done) fill_q <= div_quot;
    if (state_q == SSched) sched_q <= add_s;
    if (state_q == SFull) full_q <= add_s;
    if (state_q == SLimit) lim_q <= add_s;
    if (state_q == SMax) elig_q <= elig_max;
    if (state_q == SDecide) diff_q <= elig_q - full_q;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW - 1 - TimeW){1'b0}}, elig_out_q, acc_out_q};

endmodule

FILE: dv/ats_eligibility_time_shaper_test.sv
module ats_eligibility_time_shaper_test;
  import ats_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned TailCycles = 250;
  localparam logic [63:0] NanosPerSec = 64'd1000000000;

  typedef struct packed {
    logic             accepted;
    logic [TimeW-1:0] elig_ns;
  } frame_verdict_t;

  typedef enum logic {
    RowFrame,
    RowProgram
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [SidW-1:0]   sid;
    logic [LenW-1:0]   len;
    logic [TimeW-1:0]  now;
    logic              known;
    frame_verdict_t    verdict;
    logic [RateW-1:0]  rate;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  res;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = CfgRate;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // shaper state as the block should hold it
  logic [RateW-1:0]  rate_bps;
  logic [BurstW-1:0] burst_bits;
  logic [TimeW-1:0]  max_wait_ns;
  logic              stream_seen [DefStreams];
  logic [TimeW-1:0]  bucket_empty_at [DefStreams];
  logic [TimeW-1:0]  group_elig_ns;

  frame_verdict_t pending_verdicts[$];
  plan_row_t      plan[$];
  int unsigned    mismatch_count = 0;
  int unsigned    cycle_count = 0;
  bit             send_flat = 1'b0;

  ats_eligibility_time_shaper u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [TimeW-1:0] time_sum(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    if (a > TimeMax - b) return TimeMax;
    return a + b;
  endfunction

  function automatic logic [TimeW-1:0] span_ns(input logic [63:0] bits,
                                               input logic [RateW-1:0] bps);
    logic [63:0] q;
    q = (bits * NanosPerSec) / 64'(bps);
    return (q > 64'(TimeMax)) ? TimeMax : q[TimeW-1:0];
  endfunction

  function automatic frame_verdict_t predict_verdict(input logic [SidW-1:0] sid,
                                                     input logic [LenW-1:0] len,
                                                     input logic [TimeW-1:0] now);
    frame_verdict_t   v;
    logic [TimeW-1:0] drained_at, recover, refill, sched, full_at, elig;
    // a new stream starts with an empty bucket at now, even on a zero rate
    if (!stream_seen[sid]) begin
      stream_seen[sid]     = 1'b1;
      bucket_empty_at[sid] = now;
    end
    if (rate_bps == '0) begin
      v.accepted = 1'b0;
      v.elig_ns  = now;
      return v;
    end
    drained_at = bucket_empty_at[sid];
    recover    = span_ns(64'(len) << 3, rate_bps);
    refill     = span_ns(64'(burst_bits), rate_bps);
    sched      = time_sum(drained_at, recover);
    full_at    = time_sum(drained_at, refill);
    elig       = now;
    if (group_elig_ns > elig) elig = group_elig_ns;
    if (sched > elig) elig = sched;
    if (elig <= time_sum(now, max_wait_ns)) begin
      group_elig_ns = elig;
      bucket_empty_at[sid] = (elig < full_at) ? sched : time_sum(sched, elig - full_at);
      v.accepted = 1'b1;
    end else begin
      v.accepted = 1'b0;
    end
    v.elig_ns = elig;
    return v;
  endfunction

  function automatic plan_row_t frame_row(input logic [SidW-1:0] sid,
                                          input logic [LenW-1:0] len,
                                          input logic [TimeW-1:0] now);
    plan_row_t r;
    r      = '0;
    r.kind = RowFrame;
    r.sid  = sid;
    r.len  = len;
    r.now  = now;
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic [SidW-1:0] sid,
                                          input logic [LenW-1:0] len,
                                          input logic [TimeW-1:0] now,
                                          input logic accepted,
                                          input logic [TimeW-1:0] elig);
    plan_row_t r;
    r                  = frame_row(sid, len, now);
    r.known            = 1'b1;
    r.verdict.accepted = accepted;
    r.verdict.elig_ns  = elig;
    return r;
  endfunction

  function automatic plan_row_t program_row(input logic [RateW-1:0] rate,
                                            input logic [BurstW-1:0] burst,
                                            input logic [TimeW-1:0] res);
    plan_row_t r;
    r       = '0;
    r.kind  = RowProgram;
    r.rate  = rate;
    r.burst = burst;
    r.res   = res;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Called at a clock edge; leaves the sender on the edge that took the beat.
  task automatic offer_frame(input logic [SidW-1:0] sid, input logic [LenW-1:0] len,
                             input logic [TimeW-1:0] now, input logic known,
                             input frame_verdict_t given);
    int unsigned    gap;
    frame_verdict_t v;
    if ($urandom_range(0, 31) == 0) send_flat = !send_flat;
    gap = send_flat ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({now, len, sid});
    do @(posedge clk_i); while (!s_axis_tready);
    v = predict_verdict(sid, len, now);
    pending_verdicts.push_back(known ? given : v);
  endtask

  // Hold the sender until every outstanding verdict has been returned.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_shaper(input logic [RateW-1:0] rate,
                                input logic [BurstW-1:0] burst,
                                input logic [TimeW-1:0] res);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgRate;
    cfg_wdata_i <= CfgW'(rate);
    @(posedge clk_i);
    cfg_idx_i   <= CfgBurst;
    cfg_wdata_i <= CfgW'(burst);
    @(posedge clk_i);
    cfg_idx_i   <= CfgResidence;
    cfg_wdata_i <= CfgW'(res);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rate_bps    = rate;
    burst_bits  = burst;
    max_wait_ns = res;
  endtask

  // result side: random back-pressure, compare each beat with the oldest verdict
  initial begin
    frame_verdict_t want;
    int unsigned    stall;
    int unsigned    beat_no;
    bit             recv_flat;
    beat_no   = 0;
    recv_flat = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_flat = !recv_flat;
      stall = recv_flat ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_verdicts.size() == 0) begin
        flag_mismatch($sformatf("beat %0d arrived with nothing expected, data %h",
                                beat_no, m_axis_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.accepted)
          flag_mismatch($sformatf("beat %0d accepted %b, want %b",
                                  beat_no, m_axis_tdata[0], want.accepted));
        if (m_axis_tdata[TimeW:1] !== want.elig_ns)
          flag_mismatch($sformatf("beat %0d eligibility %0d, want %0d",
                                  beat_no, m_axis_tdata[TimeW:1], want.elig_ns));
      end
      beat_no++;
    end
  end

  initial begin
    logic [RateW-1:0]  rate;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  res, now, r;
    logic [SidW-1:0]   sid;
    logic [LenW-1:0]   len;
    logic [63:0]       spread;
    int unsigned       count, len_cap, pick;
    bit                wide;

    rate_bps      = RateReset;
    burst_bits    = BurstReset;
    max_wait_ns   = ResReset;
    group_elig_ns = '0;
    foreach (stream_seen[i]) begin
      stream_seen[i]     = 1'b0;
      bucket_empty_at[i] = '0;
    end

    // reset settings: 800 ns per byte, 1 s residence
    plan.push_back(known_row(8'd0, 14'd0, 48'd0, 1'b1, 48'd0));
    plan.push_back(known_row(8'd255, 14'd16383, 48'd1000, 1'b1, 48'd13107400));
    plan.push_back(frame_row(8'd0, 14'd1, 48'd0));
    plan.push_back(frame_row(8'd0, 14'd64, 48'd13200000));
    plan.push_back(frame_row(8'd0, 14'd1500, 48'd13200000));
    plan.push_back(frame_row(8'd0, 14'd1500, 48'd13200000));
    plan.push_back(frame_row(8'd170, 14'h2AAA, 48'h0000_5555_5555));
    plan.push_back(frame_row(8'd85, 14'h1555, 48'h0000_AAAA_AAAA));
    // far behind the group time: dropped
    plan.push_back(frame_row(8'd1, 14'd10, 48'd0));
    // zero rate: drop at now, stream 9 still created near the top of time
    plan.push_back(program_row(37'd0, 32'd16384, 48'd1000000000));
    plan.push_back(known_row(8'd9, 14'd16383, TimeMax - 48'd5, 1'b0, TimeMax - 48'd5));
    plan.push_back(known_row(8'd2, 14'd3, 48'd12345, 1'b0, 48'd12345));
    // slowest rate, largest burst, no residence: sums and durations saturate
    plan.push_back(program_row(37'd1, 32'hFFFF_FFFF, 48'd0));
    plan.push_back(known_row(8'd9, 14'd16383, 48'd0, 1'b0, TimeMax));
    plan.push_back(known_row(8'd3, 14'd0, 48'h0001_0000_0000, 1'b1, 48'h0001_0000_0000));
    plan.push_back(frame_row(8'd3, 14'd1, 48'h0001_0000_0000));
    // fastest rate with a zero burst
    plan.push_back(program_row(37'd100000000000, 32'd0, 48'd5000));
    plan.push_back(frame_row(8'd4, 14'd16383, 48'd4300000000));
    plan.push_back(frame_row(8'd4, 14'd16383, 48'd4300000000));
    plan.push_back(frame_row(8'd4, 14'd200, 48'd4300001000));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowProgram) begin
        settle();
        program_shaper(plan[i].rate, plan[i].burst, plan[i].res);
      end else begin
        offer_frame(plan[i].sid, plan[i].len, plan[i].now, plan[i].known,
                    plan[i].verdict);
      end
    end

    for (int p = 0; p < 7; p++) begin
      len_cap = 16383;
      wide    = 1'b0;
      case (p)
        0: begin
          rate = 37'd1000000000; burst = 32'd96000; res = 48'd100000; count = 150;
        end
        1: begin
          rate = 37'd100000000000; burst = 32'hFFFF_FFFF; res = 48'd0; count = 120;
        end
        2: begin
          rate  = RateW'(64'($urandom_range(1, 100000)) * 64'($urandom_range(1, 1000000)));
          burst = $urandom;
          res   = TimeW'($urandom_range(0, 1 << 20));
          count = 120;
        end
        3: begin
          // one bit per second: keep frames tiny so time does not run out
          rate = 37'd1; burst = 32'd1; res = 48'd1000000000; count = 40; len_cap = 15;
        end
        4: begin
          rate = '0; burst = $urandom; res = {16'($urandom), $urandom}; count = 30;
        end
        5: begin
          rate = 37'd10000000; burst = 32'd0; res = TimeW'($urandom_range(0, 1 << 24));
          count = 110;
        end
        default: begin
          rate  = RateW'(64'($urandom_range(1, 100000)) * 64'($urandom_range(1, 1000000)));
          burst = $urandom;
          res   = TimeMax;
          count = 130;
          wide  = 1'b1;
        end
      endcase
      settle();
      program_shaper(rate, burst, res);

      for (int k = 0; k < count; k++) begin
        // cluster most frames on a few streams so buckets see repeat traffic
        sid = ($urandom_range(0, 9) < 8) ? SidW'($urandom_range(0, 3))
                                         : SidW'($urandom_range(0, 255));
        len = LenW'($urandom_range(0, len_cap));
        spread = (rate_bps == '0) ? 64'd1000 : 64'd12000000000000 / 64'(rate_bps);
        if (spread < 64) spread = 64;
        if (spread > 64'h7FFF_FFFF) spread = 64'h7FFF_FFFF;
        r    = TimeW'($urandom_range(0, spread[31:0]));
        pick = $urandom_range(0, 9);
        // track the group time, a little behind or ahead of it, with some noise
        if (pick == 0)
          now = wide ? {16'($urandom), $urandom} : TimeW'({8'($urandom), $urandom});
        else if (pick <= 2)
          now = group_elig_ns - ((group_elig_ns < r) ? group_elig_ns : r);
        else
          now = time_sum(group_elig_ns, r);
        offer_frame(sid, len, now, 1'b0, '0);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
